// ----- sv/lpht_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the linear probe hash table.
// No dependencies.
package lpht_pkg;

  localparam int TABLE_SIZE = 128;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int KEY_W      = 16;
  localparam int TAG_W      = 32;
  localparam int GRADE_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 7;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [PADDR_W-1:0] ADDR_REPLACE_MODE = 3'd0;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TAG_W-1:0]   name_tag;
    logic [GRADE_W-1:0] grade;
  } rec_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    rec_t             data;
  } wr_req_t;

endpackage

// ----- sv/lpht_store.sv -----
`timescale 1ns / 1ps
// Record memory (registered read) and per-slot occupancy bits.
// Depends on lpht_pkg.
module lpht_store
  import lpht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IDX_W-1:0]      rd_addr,
  output rec_t                  rdata,
  input  wr_req_t               wr,
  output logic [TABLE_SIZE-1:0] slot_valid
);

  rec_t mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr.en) begin
      slot_valid[wr.addr] <= 1'b1;
    end
  end

endmodule

// ----- sv/linear_probe_hash_table.sv -----
`timescale 1ns / 1ps
// Linear probe hash table: top level with probe sequencer and APB register.
// Depends on lpht_pkg and lpht_store.
//
// Usage: one item (opcode, key, name_tag, grade) enters on the in channel
// when in_valid and in_ready are high; it yields exactly one result item on
// the out channel (status, slot, found_name_tag, found_grade).
// Items are handled one at a time. The home slot is key mod 128. An insert
// walks the occupancy bits one slot per cycle; a search reads the record
// memory one slot per cycle and compares each read in the next cycle.
// in_ready returns together with out_valid, when the result is registered.
// Reset empties the table at once (occupancy bits cleared) and sets
// replace_mode to 1. A finished result waits in the output register while
// the receiver stalls; the next item is still accepted, and its result is
// delivered once the pending one has gone. replace_mode (address 0) is
// written through the APB port; the user must write it only while the
// block is idle, as the block itself does not enforce this.
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                opcode,
  input  logic [KEY_W-1:0]    key,
  input  logic [TAG_W-1:0]    name_tag,
  input  logic [GRADE_W-1:0]  grade,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot,
  output logic [TAG_W-1:0]    found_name_tag,
  output logic [GRADE_W-1:0]  found_grade,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INS_SCAN = 6'b000010,
    S_INS_MOVE = 6'b000100,
    S_INS_PUT  = 6'b001000,
    S_SRCH     = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

  state_t state, state_next;

  logic                  replace_mode;
  logic [KEY_W-1:0]      key_r;
  logic [TAG_W-1:0]      tag_r;
  logic [GRADE_W-1:0]    grade_r;
  logic [IDX_W-1:0]      home;
  logic [IDX_W-1:0]      idx;
  logic [CNT_W-1:0]      cnt;
  logic [IDX_W-1:0]      tgt;
  logic                  pend;
  logic                  pend_vld;
  logic [IDX_W-1:0]      pend_idx;
  logic [STATUS_W-1:0]   res_status;
  logic [SLOT_W-1:0]     res_slot;
  logic [TAG_W-1:0]      res_tag;
  logic [GRADE_W-1:0]    res_grade;

  logic [IDX_W-1:0]      rd_addr;
  rec_t                  rdata;
  wr_req_t               wr;
  logic [TABLE_SIZE-1:0] slot_valid;
  logic                  accept;
  logic                  hit;
  logic                  scan_end;

  lpht_store u_store (
    .clk        (clk),
    .rst        (rst),
    .rd_addr    (rd_addr),
    .rdata      (rdata),
    .wr         (wr),
    .slot_valid (slot_valid)
  );

  assign pready   = 1'b1;
  assign prdata   = (paddr == ADDR_REPLACE_MODE) ? PDATA_W'(replace_mode) : '0;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign hit      = pend && pend_vld && (rdata.key == key_r);
  assign scan_end = (cnt == CNT_W'(TABLE_SIZE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      replace_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_REPLACE_MODE) begin
      replace_mode <= pwdata[0];
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = key[IDX_W-1:0];
      S_SRCH:  rd_addr = idx;
      default: rd_addr = home;
    endcase
  end

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = tgt;
    wr.data = '{key: key_r, name_tag: tag_r, grade: grade_r};
    unique case (state)
      S_INS_MOVE: begin
        wr.en   = 1'b1;
        wr.data = rdata;
      end
      S_INS_PUT: begin
        wr.en   = 1'b1;
        wr.addr = home;
      end
      default: ;
    endcase
    if (state == S_INS_PUT) begin
      wr.addr = tgt;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (opcode == OP_SEARCH) ? S_SRCH : S_INS_SCAN;
        end
      end
      S_INS_SCAN: begin
        if (!slot_valid[idx]) begin
          if (cnt != '0 && replace_mode && rdata.key[IDX_W-1:0] != home) begin
            state_next = S_INS_MOVE;
          end else begin
            state_next = S_INS_PUT;
          end
        end else if (scan_end) begin
          state_next = S_RESP;
        end
      end
      S_INS_MOVE: state_next = S_INS_PUT;
      S_INS_PUT:  state_next = S_RESP;
      S_SRCH: begin
        if (hit || (cnt == CNT_W'(TABLE_SIZE) && pend)) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pend <= 1'b0;
      end else if (state == S_SRCH) begin
        pend <= (cnt != CNT_W'(TABLE_SIZE));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && (!out_valid || out_ready)) begin
      status         <= res_status;
      slot           <= res_slot;
      found_name_tag <= res_tag;
      found_grade    <= res_grade;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          key_r      <= key;
          tag_r      <= name_tag;
          grade_r    <= grade;
          home       <= key[IDX_W-1:0];
          idx        <= key[IDX_W-1:0];
          cnt        <= '0;
          res_status <= (opcode == OP_SEARCH) ? ST_MISSING : ST_FULL;
          res_slot   <= '0;
          res_tag    <= '0;
          res_grade  <= '0;
        end
      end
      S_INS_SCAN: begin
        if (!slot_valid[idx]) begin
          res_status <= ST_INSERTED;
          tgt        <= idx;
          if (cnt != '0 && replace_mode && rdata.key[IDX_W-1:0] != home) begin
            res_slot <= SLOT_W'(home);
          end else begin
            res_slot <= SLOT_W'(idx);
          end
        end else begin
          idx <= idx + 1'b1;
          cnt <= cnt + 1'b1;
        end
      end
      S_INS_MOVE: begin
        tgt <= home;
      end
      S_SRCH: begin
        if (hit) begin
          res_status <= ST_FOUND;
          res_slot   <= SLOT_W'(pend_idx);
          res_tag    <= rdata.name_tag;
          res_grade  <= rdata.grade;
        end
        if (cnt != CNT_W'(TABLE_SIZE)) begin
          pend_vld <= slot_valid[idx];
          pend_idx <= idx;
          idx      <= idx + 1'b1;
          cnt      <= cnt + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
